### hw/rtl/lbrs_pkg.sv
// Shared types and constants for the bilinear remap sampler.
// Used by every module of the block but lbrs_ram; depends on nothing.
package lbrs_pkg;

  // Store geometry: 1M x 8-bit luma, split into two parity banks
  localparam int ADDR_W     = 20;
  localparam int BANK_AW    = ADDR_W - 1;
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 32;
  localparam int FRAC_MAX   = 16;

  // Stream payload widths
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 8;

  // Depth of the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  // One classified item as it travels from the front to the back
  typedef struct packed {
    action_t             act;
    logic                oob;
    logic [ADDR_W-1:0]   addr;   // write address, or top-left tap address
    logic [PIX_W-1:0]    data;
    logic [FRAC_MAX-1:0] xf;
    logic [FRAC_MAX-1:0] yf;
  } item_t;

endpackage

### hw/rtl/lbrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds its data across cycles where read is not enabled.
module lbrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/lbrs_front.sv
// Front part: accepts input transactions, runs the bounds test and forms the
// top-left tap address. Depends on lbrs_pkg.
module lbrs_front import lbrs_pkg::*; #(
  parameter int IMAGE_WIDTH   = 1024,
  parameter int IMAGE_HEIGHT  = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  output logic                 push,
  output item_t                push_item,
  input  logic                 q_full
);

  localparam int XI_W   = $clog2(IMAGE_WIDTH);
  localparam int YI_W   = $clog2(IMAGE_HEIGHT);
  localparam int BASE_W = XI_W + YI_W;
  localparam logic [63:0] X_LIM_W = 64'(IMAGE_WIDTH - 1) << FRACTION_BITS;
  localparam logic [63:0] Y_LIM_W = 64'(IMAGE_HEIGHT - 1) << FRACTION_BITS;
  localparam logic [COORD_W-1:0] X_LIM = X_LIM_W[COORD_W-1:0];
  localparam logic [COORD_W-1:0] Y_LIM = Y_LIM_W[COORD_W-1:0];

  logic [ADDR_W-1:0]  pixel_addr;
  logic [PIX_W-1:0]   pixel_value;
  logic [COORD_W-1:0] sample_x;
  logic [COORD_W-1:0] sample_y;
  logic [XI_W-1:0]    xi;
  logic [YI_W-1:0]    yi;
  logic [BASE_W-1:0]  base;
  item_t              item_next;
  item_t              held;
  logic               held_valid;
  logic               accept;

  // Unpack the input payload
  assign pixel_addr  = s_tdata[19:0];
  assign pixel_value = s_tdata[27:20];
  assign sample_x    = s_tdata[59:28];
  assign sample_y    = s_tdata[91:60];

  // Integer parts and row-major tap address
  assign xi   = sample_x[FRACTION_BITS +: XI_W];
  assign yi   = sample_y[FRACTION_BITS +: YI_W];
  assign base = BASE_W'(yi) * BASE_W'(IMAGE_WIDTH) + BASE_W'(xi);

  // Classify the item; negative and marker coordinates fail the unsigned test
  always_comb begin
    item_next      = '0;
    item_next.act  = action_t'(s_tuser);
    item_next.data = pixel_value;
    item_next.xf   = FRAC_MAX'(sample_x[FRACTION_BITS-1:0]);
    item_next.yf   = FRAC_MAX'(sample_y[FRACTION_BITS-1:0]);
    item_next.oob  = (sample_x >= X_LIM) || (sample_y >= Y_LIM);
    if (item_next.act == ACT_WRITE) begin
      item_next.addr = pixel_addr;
      item_next.oob  = 1'b0;
    end else begin
      item_next.addr = ADDR_W'(base);
    end
  end

  // Hold one classified item until the queue takes it
  assign push     = held_valid && !q_full;
  assign s_tready = !held_valid || !q_full;
  assign accept   = s_tvalid && s_tready;
  assign push_item = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (push) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= item_next;
    end
  end

  // A stalled front keeps its item
  a_held_kept: assert property (@(posedge clk) disable iff (rst)
    held_valid && q_full |=> held_valid && $stable(held))
    else $error("front item lost while the queue was full");

endmodule

### hw/rtl/lbrs_queue.sv
// Short queue of classified items between the front and the back.
// Depends on lbrs_pkg for item_t and QUEUE_DEPTH.
module lbrs_queue import lbrs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("queue read while empty");

endmodule

### hw/rtl/lbrs_back.sv
// Back part: issues writes and tap reads to the banked frame store, blends
// the four taps and drives the output register. Depends on lbrs_pkg, lbrs_ram.
module lbrs_back import lbrs_pkg::*; #(
  parameter int IMAGE_WIDTH   = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  item_t                 q_item,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser
);

  localparam int FB    = FRACTION_BITS;
  localparam int W_W   = FB + 1;
  localparam int ROW_W = FB + PIX_W;
  localparam int SUM_W = 2 * FB + PIX_W + 1;
  localparam logic [W_W-1:0] ONE = {1'b1, {FB{1'b0}}};

  logic              adv;
  logic              is_sample;
  logic              is_write;
  logic [ADDR_W-1:0] top_row;
  logic [ADDR_W-1:0] bot_row;
  logic [ADDR_W-1:0] top_even;
  logic [ADDR_W-1:0] bot_even;
  logic [PIX_W-1:0]  even_top_q, odd_top_q, even_bot_q, odd_bot_q;

  // Stage 1: taps arrive from the store
  logic           v1, oob1, par_top1, par_bot1;
  logic [FB-1:0]  xf1, yf1;
  logic [PIX_W-1:0] p00, p10, p01, p11;
  logic [W_W-1:0] wx0, wx1;

  // Stage 2: row blends
  logic             v2, oob2;
  logic [FB-1:0]    yf2;
  logic [ROW_W-1:0] top2, bot2;
  logic [W_W-1:0]   wy0, wy1;
  logic [SUM_W-1:0] col_sum;

  // Stage 3: output register
  logic             v3, oob3;
  logic [PIX_W-1:0] val3;

  // The whole back pipeline moves when the output register is free
  assign adv       = !v3 || m_tready;
  assign pop       = !q_empty && adv;
  assign is_sample = pop && (q_item.act == ACT_SAMPLE) && !q_item.oob;
  assign is_write  = pop && (q_item.act == ACT_WRITE);

  // Tap rows; the even bank serves whichever of the pair is even
  assign top_row  = q_item.addr;
  assign bot_row  = q_item.addr + ADDR_W'(IMAGE_WIDTH);
  assign top_even = top_row + ADDR_W'(top_row[0]);
  assign bot_even = bot_row + ADDR_W'(bot_row[0]);

  lbrs_ram #(.WIDTH(PIX_W), .DEPTH(1 << BANK_AW)) u_even_top (
    .clk   (clk),
    .we    (is_write && !q_item.addr[0]),
    .waddr (q_item.addr[ADDR_W-1:1]),
    .wdata (q_item.data),
    .re    (is_sample),
    .raddr (top_even[ADDR_W-1:1]),
    .rdata (even_top_q)
  );

  lbrs_ram #(.WIDTH(PIX_W), .DEPTH(1 << BANK_AW)) u_odd_top (
    .clk   (clk),
    .we    (is_write && q_item.addr[0]),
    .waddr (q_item.addr[ADDR_W-1:1]),
    .wdata (q_item.data),
    .re    (is_sample),
    .raddr (top_row[ADDR_W-1:1]),
    .rdata (odd_top_q)
  );

  lbrs_ram #(.WIDTH(PIX_W), .DEPTH(1 << BANK_AW)) u_even_bot (
    .clk   (clk),
    .we    (is_write && !q_item.addr[0]),
    .waddr (q_item.addr[ADDR_W-1:1]),
    .wdata (q_item.data),
    .re    (is_sample),
    .raddr (bot_even[ADDR_W-1:1]),
    .rdata (even_bot_q)
  );

  lbrs_ram #(.WIDTH(PIX_W), .DEPTH(1 << BANK_AW)) u_odd_bot (
    .clk   (clk),
    .we    (is_write && q_item.addr[0]),
    .waddr (q_item.addr[ADDR_W-1:1]),
    .wdata (q_item.data),
    .re    (is_sample),
    .raddr (bot_row[ADDR_W-1:1]),
    .rdata (odd_bot_q)
  );

  // Stage 1 control; writes leave the pipeline at issue
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= pop && (q_item.act == ACT_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oob1     <= q_item.oob;
      par_top1 <= top_row[0];
      par_bot1 <= bot_row[0];
      xf1      <= q_item.xf[FB-1:0];
      yf1      <= q_item.yf[FB-1:0];
    end
  end

  // Steer bank outputs to left and right taps
  assign p00 = par_top1 ? odd_top_q  : even_top_q;
  assign p10 = par_top1 ? even_top_q : odd_top_q;
  assign p01 = par_bot1 ? odd_bot_q  : even_bot_q;
  assign p11 = par_bot1 ? even_bot_q : odd_bot_q;
  assign wx1 = W_W'(xf1);
  assign wx0 = ONE - wx1;

  // Stage 2: row blends
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oob2 <= oob1;
      yf2  <= yf1;
      top2 <= ROW_W'(wx0 * p00) + ROW_W'(wx1 * p10);
      bot2 <= ROW_W'(wx0 * p01) + ROW_W'(wx1 * p11);
    end
  end

  // Column blend, truncated by the combined fraction width
  assign wy1     = W_W'(yf2);
  assign wy0     = ONE - wy1;
  assign col_sum = SUM_W'(wy0 * top2) + SUM_W'(wy1 * bot2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oob3 <= oob2;
      val3 <= oob2 ? '0 : col_sum[2*FB +: PIX_W];
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = val3;
  assign m_tuser  = oob3;

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    adv && pop && (q_item.act == ACT_WRITE) |=> !v1)
    else $error("write item entered the blend pipeline");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v1) && $stable(v2) && v3)
    else $error("back pipeline moved while the output was stalled");

endmodule

### hw/rtl/lut_bilinear_remap_sampler.sv
// Bilinear remap sampler, top level: front, queue and back wired together.
// Depends on lbrs_pkg, lbrs_front, lbrs_queue, lbrs_back and lbrs_ram.
//
// The block holds one 8-bit source frame (row-major, row times IMAGE_WIDTH plus
// column, addresses wrap at 2^20). A transaction with tuser low writes one
// pixel and produces no output; with tuser high it samples at a signed
// coordinate pair with FRACTION_BITS fraction bits and produces one output:
// the bilinear blend of the four neighbor taps, or zero with tuser set when a
// coordinate is outside [0, (dimension-1) << FRACTION_BITS). Unless the output
// stalls, the block takes one transaction per clock cycle, writes and samples
// alike, because the store is split into even and odd address banks, each kept
// as two copies (top and bottom tap row), so all four taps are read in the same
// cycle. A sample passes the front register, a queue slot, the tap read, the row
// blend and the output register before m_tvalid rises. While the output is
// held, the four-entry queue and the front's holding register take up to five
// more input transactions before s_tready drops. The store needs no clearing
// after reset; reading a never-written pixel gives an undefined value.
module lut_bilinear_remap_sampler import lbrs_pkg::*; #(
  parameter int IMAGE_WIDTH   = 1024,
  parameter int IMAGE_HEIGHT  = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // pixel_addr[19:0], pixel_value[27:20], sample_x[59:28], sample_y[91:60], zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // action[0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // sample_value[7:0]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // out_of_bounds[0]
  output logic                  m_tuser
);

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  pop;
  item_t pop_item;
  logic  q_empty;

  lbrs_front #(
    .IMAGE_WIDTH   (IMAGE_WIDTH),
    .IMAGE_HEIGHT  (IMAGE_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  lbrs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  lbrs_back #(
    .IMAGE_WIDTH   (IMAGE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_item   (pop_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
